// File: hdl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_EQ  = 3'd5
    } op_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZDEN  = 2'd1,
        ST_DIV0  = 2'd2,
        ST_OVF   = 2'd3
    } status_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_SUM  = 9'b000000100,
        S_GCDI = 9'b000001000,
        S_GCD  = 9'b000010000,
        S_DIVI = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_CHK  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

endpackage
`default_nettype wire

// File: hdl/rational_arith_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence per word: an error word skips the arithmetic; equality compares the
// cross products; other ops form three products, run a binary GCD on the numerator
// and denominator built from them (the A operand itself for negate), then two
// restoring divides by the gcd (numerator, then denominator) and a range check.
// Throughput: one word at a time; in_stall is high from accept until the result leaves.
// Reset: rst_n asynchronous active low; clears the sequencer and the output valid.
module rational_arith_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  op,
    input  wire logic [31:0] a_num,
    input  wire logic [31:0] a_den,
    input  wire logic [31:0] b_num,
    input  wire logic [31:0] b_den,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      res_num,
    output logic [30:0]      res_den,
    output logic             is_equal,
    output logic [1:0]       status
);

    localparam int W  = WORD_BITS;
    localparam int D  = 2 * W;
    localparam int CW = $clog2(D + 1);

    state_t state_reg, state_next;

    // Sign/magnitude operands, low W bits of each port.
    logic          an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [W-1:0]  an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic [2:0]    op_reg;
    logic [1:0]    mcnt_reg;

    // Products and working values.
    logic [D-1:0]  p_reg [3];
    logic [D:0]    n_reg;          // numerator magnitude (sum may carry)
    logic          n_s_reg;
    logic [D-1:0]  d_reg;          // denominator magnitude
    logic          d_s_reg;
    logic [D:0]    x_reg, y_reg;   // GCD working pair
    logic [CW:0]   k_reg;          // common power of two
    logic [D:0]    g_reg;          // gcd
    logic [D:0]    q_reg, r_reg;   // divide quotient/remainder
    logic          dsel_reg;       // 0 dividing numerator, 1 denominator
    logic [D:0]    nq_reg;
    logic [CW:0]   cnt_reg;

    logic [31:0]   res_num_reg;
    logic [30:0]   res_den_reg;
    logic          eq_reg;
    logic [1:0]    st_reg;
    logic          ovf;

    function automatic logic [W-1:0] mag_of(input logic [31:0] v);
        logic [W-1:0] t;
        t = v[W-1:0];
        return t[W-1] ? (~t + 1'b1) : t;
    endfunction

    // Shared multiplier operand mux.
    logic [W-1:0] ma, mb;
    logic [D-1:0] mprod;
    always_comb
    begin
        ma = an_m_reg;
        mb = bd_m_reg;
        case (mcnt_reg)
            2'd0:
            begin
                ma = an_m_reg;
                mb = (op_reg == OP_MUL) ? bn_m_reg : bd_m_reg;
            end
            2'd1:
            begin
                ma = (op_reg == OP_DIV) ? ad_m_reg : bn_m_reg;
                mb = (op_reg == OP_DIV) ? bn_m_reg : ad_m_reg;
            end
            2'd2:
            begin
                ma = ad_m_reg;
                mb = bd_m_reg;
            end
            default:
            begin
                ma = ad_m_reg;
                mb = bd_m_reg;
            end
        endcase
        mprod = D'(ma) * D'(mb);
    end

    // Shared subtractor.
    logic [D+1:0] sub;
    logic [D:0]   sa, sb;
    always_comb
    begin
        sa = x_reg;
        sb = y_reg;
        if (state_reg == S_DIV)
        begin
            sa = {r_reg[D-1:0], q_reg[D]};
            sb = g_reg;
        end
        else if (state_reg == S_SUM)
        begin
            sa = {1'b0, p_reg[0]};
            sb = {1'b0, p_reg[1]};
        end
        sub = {1'b0, sa} - {1'b0, sb};
    end

    logic         s_l, s_r;
    logic [D:0]   half_m, half_n;
    always_comb
    begin
        s_l = (an_s_reg ^ ((op_reg == OP_MUL) ? bn_s_reg : bd_s_reg)) && (p_reg[0] != '0);
        s_r = (op_reg == OP_DIV) ? ((ad_s_reg ^ bn_s_reg) && (p_reg[1] != '0))
                                 : ((bn_s_reg ^ ad_s_reg) && (p_reg[1] != '0));
        if (op_reg == OP_SUB)
            s_r = !(bn_s_reg ^ ad_s_reg) && (p_reg[1] != '0);
        half_n  = (D+1)'(1) << (W - 1);
        half_m  = half_n - 1'b1;
        // reduced result must fit the W-bit format
        ovf     = (q_reg > half_m) ||
                  (n_s_reg ? (nq_reg > half_n) : (nq_reg > half_m));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_MUL;
            S_MUL:  if (st_reg != ST_OK) state_next = S_OUT;
                    else if (mcnt_reg == 2'd2) state_next = S_SUM;
            S_SUM:  state_next = (op_reg == OP_EQ) ? S_OUT : S_GCDI;
            S_GCDI: state_next = S_GCD;
            S_GCD:  if (y_reg == '0 || x_reg == '0) state_next = S_DIVI;
            S_DIVI: state_next = S_DIV;
            S_DIV:  if (cnt_reg == '0) state_next = dsel_reg ? S_CHK : S_DIVI;
            S_CHK:  state_next = S_OUT;
            S_OUT:  if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg   <= op;
                an_m_reg <= mag_of(a_num); an_s_reg <= a_num[W-1];
                ad_m_reg <= mag_of(a_den); ad_s_reg <= a_den[W-1];
                bn_m_reg <= mag_of(b_num); bn_s_reg <= b_num[W-1];
                bd_m_reg <= mag_of(b_den); bd_s_reg <= b_den[W-1];
                mcnt_reg <= 2'd0;
                eq_reg   <= 1'b0;
                dsel_reg <= 1'b0;
                res_num_reg <= '0;
                res_den_reg <= '0;
                if (a_den[W-1:0] == '0 || (op <= OP_EQ && b_den[W-1:0] == '0))
                    st_reg <= ST_ZDEN;
                else if (op == OP_DIV && b_num[W-1:0] == '0)
                    st_reg <= ST_DIV0;
                else
                    st_reg <= ST_OK;
            end
            S_MUL:
            begin
                p_reg[mcnt_reg] <= mprod;
                mcnt_reg <= mcnt_reg + 2'd1;
            end
            S_SUM:
            begin
                // numerator and denominator signs/magnitudes
                if (op_reg == OP_ADD || op_reg == OP_SUB)
                begin
                    d_reg   <= p_reg[2];
                    d_s_reg <= ad_s_reg ^ bd_s_reg;
                    if (s_l == s_r)
                    begin
                        n_reg   <= {1'b0, p_reg[0]} + {1'b0, p_reg[1]};
                        n_s_reg <= s_l;
                    end
                    else if (!sub[D+1])
                    begin
                        n_reg   <= sub[D:0];
                        n_s_reg <= s_l;
                    end
                    else
                    begin
                        n_reg   <= (D+1)'(0) - sub[D:0];
                        n_s_reg <= s_r;
                    end
                end
                else if (op_reg == OP_MUL)
                begin
                    n_reg   <= {1'b0, p_reg[0]};
                    n_s_reg <= s_l;
                    d_reg   <= p_reg[2];
                    d_s_reg <= ad_s_reg ^ bd_s_reg;
                end
                else if (op_reg == OP_DIV)
                begin
                    n_reg   <= {1'b0, p_reg[0]};
                    n_s_reg <= s_l;
                    d_reg   <= p_reg[1];
                    d_s_reg <= ad_s_reg ^ bn_s_reg;
                end
                else
                begin
                    n_reg   <= {{(D+1-W){1'b0}}, an_m_reg};
                    n_s_reg <= (op_reg == OP_NEG) ? !an_s_reg : an_s_reg;
                    d_reg   <= {{(D-W){1'b0}}, ad_m_reg};
                    d_s_reg <= ad_s_reg;
                end
                eq_reg <= (s_l == s_r || p_reg[0] == '0) && (p_reg[0] == p_reg[1]);
            end
            S_GCDI:
            begin
                x_reg <= n_reg;
                y_reg <= {1'b0, d_reg};
                k_reg <= '0;
                if (n_reg == '0) n_s_reg <= 1'b0;
                else n_s_reg <= n_s_reg ^ d_s_reg;
            end
            S_GCD:
            begin
                // binary GCD, one step per cycle
                if (x_reg == '0)
                    g_reg <= y_reg << k_reg;
                else if (y_reg == '0)
                    g_reg <= x_reg << k_reg;
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!x_reg[0])
                    x_reg <= x_reg >> 1;
                else if (!y_reg[0])
                    y_reg <= y_reg >> 1;
                else if (!sub[D+1])
                    x_reg <= sub[D:0] >> 1;
                else
                    y_reg <= ((D+1)'(0) - sub[D:0]) >> 1;
            end
            S_DIVI:
            begin
                q_reg   <= dsel_reg ? {1'b0, d_reg} : n_reg;
                r_reg   <= '0;
                cnt_reg <= (CW+1)'(D + 1);
            end
            S_DIV:
            begin
                // restoring divide, one quotient bit per cycle, D+1 steps
                if (cnt_reg != '0)
                begin
                    if (!sub[D+1])
                    begin
                        r_reg <= sub[D:0];
                        q_reg <= {q_reg[D-1:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= {r_reg[D-1:0], q_reg[D]};
                        q_reg <= {q_reg[D-1:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    if (!dsel_reg) nq_reg <= q_reg;
                    dsel_reg <= 1'b1;
                end
            end
            S_CHK:
            begin
                if (ovf)
                    st_reg <= ST_OVF;
                else
                begin
                    res_num_reg <= 32'($signed(W'(n_s_reg ? (~nq_reg + 1'b1) : nq_reg)));
                    res_den_reg <= 31'(q_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign res_num   = (st_reg == ST_OK && op_reg != OP_EQ) ? res_num_reg : '0;
    assign res_den   = (st_reg == ST_OK && op_reg != OP_EQ) ? res_den_reg : '0;
    assign is_equal  = (st_reg == ST_OK && op_reg == OP_EQ) ? eq_reg : 1'b0;
    assign status    = st_reg;

endmodule
`default_nettype wire

// File: hdl/rau_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rau_checker
    import rau_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] res_num,
    input wire logic [30:0] res_den,
    input wire logic        is_equal,
    input wire logic [1:0]  status
);

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> res_num == '0 && res_den == '0 && !is_equal)
        else $error("error word carries data");

    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && !is_equal && res_num != '0 |-> res_den != '0)
        else $error("zero denominator on ok word");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("accepting while result pending");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result in the cycle after accept");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(status))
        else $error("stalled word changed");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .res_num(res_num),
    .res_den(res_den), .is_equal(is_equal), .status(status)
);
`default_nettype wire
